// ===== rtl/sotc_pkg.sv =====
// shared types, constants and cordic step functions for the spherical offset block
package sotc_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CW = 34;

  typedef logic signed [CW-1:0] cword_t;

  typedef struct packed {
    cword_t x;
    cword_t y;
    cword_t z;
  } crd_t;

  localparam cword_t CORDIC_K = 34'sd652032874;
  localparam cword_t ONE_Q30 = 34'sd1073741824;

  // arctangent of 2^-idx in 2^32-per-turn units
  function automatic cword_t atan_turn(input int idx);
    cword_t r;
    case (idx)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // one rotation-mode micro-rotation, floor shifts
  function automatic crd_t cordic_step(input crd_t a, input int idx);
    cword_t dx;
    cword_t dy;
    cword_t at;
    crd_t r;
    dx = a.y >>> idx;
    dy = a.x >>> idx;
    at = atan_turn(idx);
    if (!a.z[CW-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - at;
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + at;
    end
    return r;
  endfunction

  // clamp to [-1, 1] in q1.30
  function automatic logic signed [31:0] clamp_q30(input cword_t v);
    logic signed [31:0] r;
    if (v > ONE_Q30) begin
      r = 32'sd1073741824;
    end else if (v < -ONE_Q30) begin
      r = -32'sd1073741824;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/sotc_cell.sv =====
// one cordic cell: rotates heading and tilt vectors by one step and forwards the payload
module sotc_cell #(
  parameter int IDX = 0,
  parameter int PW = 129
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sotc_pkg::crd_t  in_h,
  input  sotc_pkg::crd_t  in_e,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  input  logic            out_ready,
  output sotc_pkg::crd_t  out_h,
  output sotc_pkg::crd_t  out_e,
  output logic [PW-1:0]   out_pay
);

  logic v;

  assign in_ready = !v || out_ready;
  assign out_valid = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_h <= sotc_pkg::cordic_step(in_h, IDX);
      out_e <= sotc_pkg::cordic_step(in_e, IDX);
      out_pay <= in_pay;
    end
  end

endmodule

// ===== rtl/sotc_mul.sv =====
// product, rounding and saturation pipeline behind the cordic chain, ends in the output register
module sotc_mul #(
  parameter int W = 32,
  parameter int OUT_W = 96
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sotc_pkg::crd_t    in_h,
  input  sotc_pkg::crd_t    in_e,
  input  logic              in_flip,
  input  logic [W-1:0]      in_ox,
  input  logic [W-1:0]      in_oy,
  input  logic [W-1:0]      in_oz,
  input  logic [W-1:0]      in_reach,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata
);

  localparam int LW = (W + 1) / 2;
  localparam int HW = W - LW;
  localparam int NS = 6;
  localparam logic signed [W+2:0] SMAX = $signed({4'b0000, {(W-1){1'b1}}});
  localparam logic signed [W+2:0] SMIN = $signed({4'b1111, {(W-1){1'b0}}});

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];
  assign m_tvalid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  function automatic logic [30:0] mag31(input logic signed [31:0] a);
    return a[31] ? 31'(-a) : 31'(a);
  endfunction

  // stage a: clamp and quadrant fold
  logic signed [31:0] a_cd, a_sd, a_ce, a_se;
  logic [W-1:0] a_ox, a_oy, a_oz, a_reach;
  logic signed [31:0] cdc, sdc;

  assign cdc = sotc_pkg::clamp_q30(in_h.x);
  assign sdc = sotc_pkg::clamp_q30(in_h.y);

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      a_cd <= in_flip ? -cdc : cdc;
      a_sd <= in_flip ? -sdc : sdc;
      a_ce <= sotc_pkg::clamp_q30(in_e.x);
      a_se <= sotc_pkg::clamp_q30(in_e.y);
      a_ox <= in_ox;
      a_oy <= in_oy;
      a_oz <= in_oz;
      a_reach <= in_reach;
    end
  end

  // stage b: cos(elev) times sin and cos of heading
  logic [61:0] b_px, b_pz;
  logic b_nx, b_nz, b_ny;
  logic [30:0] b_ry;
  logic [W-1:0] b_ox, b_oy, b_oz, b_reach;
  logic [61:0] px, pz;

  assign px = {31'b0, mag31(a_ce)} * {31'b0, mag31(a_sd)};
  assign pz = {31'b0, mag31(a_ce)} * {31'b0, mag31(a_cd)};

  always_ff @(posedge clk) begin
    if (en[1] && v[0]) begin
      b_px <= px;
      b_pz <= pz;
      b_nx <= a_ce[31] ^ a_sd[31];
      b_nz <= a_ce[31] ^ a_cd[31];
      b_ry <= mag31(a_se);
      b_ny <= a_se[31];
      b_ox <= a_ox;
      b_oy <= a_oy;
      b_oz <= a_oz;
      b_reach <= a_reach;
    end
  end

  // stage c: round factors, magnitude of reach
  logic [30:0] c_rx, c_ry, c_rz;
  logic c_nx, c_ny, c_nz;
  logic [W-1:0] c_ra;
  logic [W-1:0] c_ox, c_oy, c_oz;
  logic [61:0] rxs, rzs;

  assign rxs = (b_px + 62'd536870912) >> 30;
  assign rzs = (b_pz + 62'd536870912) >> 30;

  always_ff @(posedge clk) begin
    if (en[2] && v[1]) begin
      c_rx <= rxs[30:0];
      c_rz <= rzs[30:0];
      c_ry <= b_ry;
      c_nx <= b_nx ^ b_reach[W-1];
      c_ny <= b_ny ^ b_reach[W-1];
      c_nz <= b_nz ^ b_reach[W-1];
      c_ra <= b_reach[W-1] ? W'(-b_reach) : b_reach;
      c_ox <= b_ox;
      c_oy <= b_oy;
      c_oz <= b_oz;
    end
  end

  // stage d: split partial products of reach times factor
  logic [LW+30:0] d_plx, d_ply, d_plz;
  logic [HW+30:0] d_phx, d_phy, d_phz;
  logic d_nx, d_ny, d_nz;
  logic [W-1:0] d_ox, d_oy, d_oz;
  logic [LW-1:0] ra_lo;
  logic [HW-1:0] ra_hi;

  assign ra_lo = c_ra[LW-1:0];
  assign ra_hi = c_ra[W-1:LW];

  always_ff @(posedge clk) begin
    if (en[3] && v[2]) begin
      d_plx <= (LW+31)'(ra_lo) * (LW+31)'(c_rx);
      d_ply <= (LW+31)'(ra_lo) * (LW+31)'(c_ry);
      d_plz <= (LW+31)'(ra_lo) * (LW+31)'(c_rz);
      d_phx <= (HW+31)'(ra_hi) * (HW+31)'(c_rx);
      d_phy <= (HW+31)'(ra_hi) * (HW+31)'(c_ry);
      d_phz <= (HW+31)'(ra_hi) * (HW+31)'(c_rz);
      d_nx <= c_nx;
      d_ny <= c_ny;
      d_nz <= c_nz;
      d_ox <= c_ox;
      d_oy <= c_oy;
      d_oz <= c_oz;
    end
  end

  // stage e: recombine and round half away from zero
  logic [W+1:0] e_rx, e_ry, e_rz;
  logic e_nx, e_ny, e_nz;
  logic [W-1:0] e_ox, e_oy, e_oz;
  logic [W+31:0] mx, my, mz;

  assign mx = {1'b0, d_phx, LW'(0)} + (W+32)'(d_plx) + (W+32)'(536870912);
  assign my = {1'b0, d_phy, LW'(0)} + (W+32)'(d_ply) + (W+32)'(536870912);
  assign mz = {1'b0, d_phz, LW'(0)} + (W+32)'(d_plz) + (W+32)'(536870912);

  always_ff @(posedge clk) begin
    if (en[4] && v[3]) begin
      e_rx <= mx[W+31:30];
      e_ry <= my[W+31:30];
      e_rz <= mz[W+31:30];
      e_nx <= d_nx;
      e_ny <= d_ny;
      e_nz <= d_nz;
      e_ox <= d_ox;
      e_oy <= d_oy;
      e_oz <= d_oz;
    end
  end

  // stage f: add origin and saturate into the output register
  function automatic logic [W-1:0] add_sat(input logic [W-1:0] o, input logic [W+1:0] r,
                                           input logic n);
    logic signed [W+2:0] s;
    logic signed [W+2:0] d;
    logic [W-1:0] q;
    d = $signed({1'b0, r});
    s = (W+3)'($signed(o)) + (n ? -d : d);
    if (s > SMAX) begin
      q = SMAX[W-1:0];
    end else if (s < SMIN) begin
      q = SMIN[W-1:0];
    end else begin
      q = s[W-1:0];
    end
    return q;
  endfunction

  logic [W-1:0] f_x, f_y, f_z;

  always_ff @(posedge clk) begin
    if (en[5] && v[4]) begin
      f_x <= add_sat(e_ox, e_rx, e_nx);
      f_y <= add_sat(e_oy, e_ry, e_ny);
      f_z <= add_sat(e_oz, e_rz, e_nz);
    end
  end

  assign m_tdata = OUT_W'({f_z, f_y, f_x});

  // rounded factors never exceed one in q1.30
  a_fac_range: assert property (@(posedge clk) disable iff (rst)
    v[2] |-> (c_rx <= 31'd1073741824) && (c_rz <= 31'd1073741824))
    else $error("rounded factor out of range");

  // a stalled output never loses the item held behind it
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (v[5] && !m_tready && v[4]) |=> (v[5] && v[4]))
    else $error("item dropped under stall");

  // a full pipe with a stalled output refuses new items
  a_full: assert property (@(posedge clk) disable iff (rst)
    ((&v) && !m_tready) |-> !in_ready)
    else $error("accepted into a full pipe");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

// ===== rtl/spherical_offset_to_cartesian.sv =====
// top level: angle preparation, cordic cell chain and product pipeline
//
// channel  dir  handshake           contents
// s_*      in   tvalid/tready       origin, heading, tilt, reach
// m_*      out  tvalid/tready       saturated result point
//
// one item per cycle sustained while m_tready stays high
// the pipe is the 24 cordic cells followed by the six product/round/saturate stages
// each stage holds its item while the one after it is full and stalled, so bubbles close up
// reset clears only the valid bits; payload registers are left as they are
// a stalled output stops the pipe only once every stage holds an item
module spherical_offset_to_cartesian #(
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // origin_x, origin_y, origin_z, heading, tilt, reach, zero fill
  input  logic [((4*COORD_BITS+2*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // result_x, result_y, result_z, zero fill
  output logic [((3*COORD_BITS+7)/8)*8-1:0] m_tdata
);

  localparam int W = COORD_BITS;
  localparam int AB = ANGLE_BITS;
  localparam int OUT_W = ((3*COORD_BITS+7)/8)*8;
  localparam int NST = sotc_pkg::CORDIC_STEPS;
  localparam int PW = 4 * W + 1;

  // unpack the input transfer
  logic [W-1:0] origin_x, origin_y, origin_z, reach;
  logic [AB-1:0] heading, tilt;

  assign origin_x = s_tdata[W-1:0];
  assign origin_y = s_tdata[2*W-1:W];
  assign origin_z = s_tdata[3*W-1:2*W];
  assign heading = s_tdata[3*W+AB-1:3*W];
  assign tilt = s_tdata[3*W+2*AB-1:3*W+AB];
  assign reach = s_tdata[4*W+2*AB-1:3*W+2*AB];

  // heading scaled to 2^32 per turn; quadrants two and three fold by a half turn
  logic [31:0] t_raw, t_fold;
  logic flip;
  logic [30:0] tl_sh;
  sotc_pkg::crd_t h0, e0;

  assign t_raw = {heading, (32-AB)'(0)};
  assign flip = t_raw[31] ^ t_raw[30];
  assign t_fold = flip ? (t_raw ^ 32'h80000000) : t_raw;
  // tilt maps onto minus to plus a quarter turn
  assign tl_sh = {tilt, (31-AB)'(0)};

  always_comb begin
    h0.x = sotc_pkg::CORDIC_K;
    h0.y = '0;
    h0.z = sotc_pkg::CW'($signed(t_fold));
    e0.x = sotc_pkg::CORDIC_K;
    e0.y = '0;
    e0.z = $signed({3'b000, tl_sh}) - sotc_pkg::ONE_Q30;
  end

  // chain of cordic cells, both rotations side by side
  sotc_pkg::crd_t ch_h [0:NST];
  sotc_pkg::crd_t ch_e [0:NST];
  logic [PW-1:0] ch_pay [0:NST];
  logic [NST:0] ch_valid;
  logic [NST:0] ch_ready;

  assign ch_h[0] = h0;
  assign ch_e[0] = e0;
  assign ch_pay[0] = {flip, reach, origin_z, origin_y, origin_x};
  assign ch_valid[0] = s_tvalid;
  assign s_tready = ch_ready[0];

  for (genvar i = 0; i < NST; i++) begin : g_cell
    sotc_cell #(
      .IDX(i),
      .PW (PW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (ch_valid[i]),
      .in_ready (ch_ready[i]),
      .in_h     (ch_h[i]),
      .in_e     (ch_e[i]),
      .in_pay   (ch_pay[i]),
      .out_valid(ch_valid[i+1]),
      .out_ready(ch_ready[i+1]),
      .out_h    (ch_h[i+1]),
      .out_e    (ch_e[i+1]),
      .out_pay  (ch_pay[i+1])
    );
  end

  // products, rounding, origin add and saturation
  sotc_mul #(
    .W    (W),
    .OUT_W(OUT_W)
  ) u_mul (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ch_valid[NST]),
    .in_ready (ch_ready[NST]),
    .in_h     (ch_h[NST]),
    .in_e     (ch_e[NST]),
    .in_flip  (ch_pay[NST][4*W]),
    .in_ox    (ch_pay[NST][W-1:0]),
    .in_oy    (ch_pay[NST][2*W-1:W]),
    .in_oz    (ch_pay[NST][3*W-1:2*W]),
    .in_reach (ch_pay[NST][4*W-1:3*W]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== test/tb_spherical_offset_to_cartesian.sv =====
// testbench for the spherical offset to cartesian block: directed and random points
module tb_spherical_offset_to_cartesian;

  localparam int AB = 16;
  localparam int CB = 32;
  localparam int SW = ((4*CB+2*AB+7)/8)*8;
  localparam int MW = ((3*CB+7)/8)*8;
  localparam int LATENCY = 30;

  // x in the lowest bits, as on m_tdata
  typedef struct packed {
    logic signed [CB-1:0] z;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] x;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [MW-1:0] m_tdata;

  point_t expected_points[$];
  int mismatches = 0;
  int points_sent = 0;
  int points_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  spherical_offset_to_cartesian #(.ANGLE_BITS(AB), .COORD_BITS(CB)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

  localparam logic [31:0] ATAN_TBL [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  function automatic longint clamp_unit(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  // rotation-mode sine/cosine, angle in 2^32 units per turn
  function automatic void rotate_unit(longint angle, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = angle;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_TBL[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_TBL[i]);
      end
    end
    c = clamp_unit(x);
    s = clamp_unit(y);
  endfunction

  // round(a*f/2^30) half away from zero, exact in 128 bits
  function automatic longint scale_q30(longint a, longint f);
    logic signed [127:0] p;
    logic [127:0] m;
    p = 128'(signed'(a)) * 128'(signed'(f));
    m = p < 0 ? -p : p;
    m = (m + (128'd1 << 29)) >> 30;
    return p < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [CB-1:0] clip_coord(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[CB-1:0];
  endfunction

  function automatic point_t offset_point(logic [SW-1:0] d);
    longint ox, oy, oz, rch, st, phi, cd, sd, ce, se;
    logic [31:0] t;
    logic flip;
    point_t r;
    ox = longint'(signed'(d[CB-1:0]));
    oy = longint'(signed'(d[2*CB-1:CB]));
    oz = longint'(signed'(d[3*CB-1:2*CB]));
    t = {d[3*CB+AB-1:3*CB], 16'h0};
    phi = longint'({d[3*CB+2*AB-1:3*CB+AB], 15'h0}) - 64'sd1073741824;
    rch = longint'(signed'(d[4*CB+2*AB-1:3*CB+2*AB]));
    flip = (t >= 32'h40000000) && (t < 32'hC0000000);
    if (flip) t = t - 32'h80000000;
    st = longint'(signed'(t));
    rotate_unit(st, cd, sd);
    if (flip) begin
      cd = -cd; sd = -sd;
    end
    rotate_unit(phi, ce, se);
    r.x = clip_coord(ox + scale_q30(rch, scale_q30(ce, sd)));
    r.y = clip_coord(oy + scale_q30(rch, se));
    r.z = clip_coord(oz + scale_q30(rch, scale_q30(ce, cd)));
    return r;
  endfunction

  // one point transfer; valid stays high across back-to-back items unless an idle gap is drawn
  task automatic send_point(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [15:0] hd, logic [15:0] tl, logic [31:0] rch);
    logic [SW-1:0] d;
    d = {rch, tl, hd, oz, oy, ox};
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_points.push_back(offset_point(d));
    points_sent++;
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // receiver stall at the falling edge
  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result check at the rising edge
  always @(posedge clk) begin
    point_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[3*CB-1:0];
      points_seen++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: x expected %h actual %h", $time, want.x, got.x);
          mismatches++;
        end
        if (got.y !== want.y) begin
          $display("%0t: y expected %h actual %h", $time, want.y, got.y);
          mismatches++;
        end
        if (got.z !== want.z) begin
          $display("%0t: z expected %h actual %h", $time, want.z, got.z);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff - $urandom_range(3);
      1: return 32'h80000000 + $urandom_range(3);
      2: return $urandom_range(2000) << 16;
      3: return -($urandom_range(2000) << 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(4))
      0: return {2'($urandom_range(3)), 14'h0};
      1: return 16'hffff - 16'($urandom_range(2));
      2: return 16'({2'($urandom_range(3)), 14'h0} + $urandom_range(4) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  // extremes, all four quadrant edges, negative reach and saturation
  task automatic test_directed();
    logic [15:0] ang [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h3fff};
    foreach (ang[i]) send_point(32'h0, 32'h0, 32'h0, ang[i], ang[5-i], 32'h00010000);
    send_point(32'h0, 32'h0, 32'h0, 16'h2000, 16'hffff, 32'h7fffffff);
    send_point(32'h0, 32'h0, 32'h0, 16'h6000, 16'h0000, 32'h80000000);
    send_point(32'h0, 32'h0, 32'h0, 16'hffff, 16'h8000, 32'hffff0000);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h2000, 16'hc000, 32'h7fffffff);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 16'h2000, 16'hc000, 32'h80000000);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 16'ha000, 16'h4000, 32'h7fffffff);
    send_point(32'h12345678, 32'hedcba987, 32'h0, 16'h0000, 16'h8000, 32'h0);
    send_point(32'hffffffff, 32'h55555555, 32'haaaaaaaa, 16'h5555, 16'haaaa, 32'h00000001);
    send_point(32'h0, 32'hffffffff, 32'h0, 16'haaaa, 16'h5555, 32'hffffffff);
    drain_pipe();
  endtask

  task automatic test_random(int count);
    repeat (count) send_point(pick_coord(), pick_coord(), pick_coord(),
                              pick_angle(), pick_angle(), pick_coord());
    drain_pipe();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    send_idle_pct = 13; recv_stall_pct = 69;
    test_random(550);
    send_idle_pct = 69; recv_stall_pct = 13;
    test_random(550);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(550);
    $display("sent %0d points, checked %0d results, over three idle/stall mixes",
             points_sent, points_seen);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
